>>> rtl/core/accumulator_cpu_step_top_assert.svh
// Assertion macros for the accumulator step block and its port checker.
// Needs a clock and an active-low reset named in each use; no other dependencies.
`ifndef ACCUMULATOR_CPU_STEP_TOP_ASSERT_SVH
`define ACCUMULATOR_CPU_STEP_TOP_ASSERT_SVH

// Same-cycle implication, off while reset is held.
`define ACS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("accumulator step port check failed");

// Next-cycle implication, off while reset is held.
`define ACS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("accumulator step port check failed");

`endif

>>> rtl/core/acs_pkg.sv
// Shared types, codes and the accumulator ALU for the accumulator step block.
// No dependencies; used by every module of the block.
`default_nettype none

package acs_pkg;

    localparam int WORD_BITS = 16;
    localparam int ADDR_BITS = 13;
    localparam int OPC_BITS  = WORD_BITS - ADDR_BITS;

    typedef enum logic [1:0] {
        ACT_WRITE  = 2'd0,
        ACT_READ   = 2'd1,
        ACT_SET_IP = 2'd2,
        ACT_EXEC   = 2'd3
    } action_t;

    typedef enum logic [OPC_BITS-1:0] {
        OP_LOAD  = 3'd0,
        OP_ADD   = 3'd1,
        OP_NEG   = 3'd2,
        OP_SUB   = 3'd3,
        OP_STORE = 3'd4,
        OP_JNEG  = 3'd5,
        OP_JUMP  = 3'd6,
        OP_NOP   = 3'd7
    } opcode_t;

    // Memory port request, driven by the sequencer.
    typedef struct packed {
        logic                 wr_en;
        logic                 rd_en;
        logic [WORD_BITS-1:0] wr_data;
    } mem_req_t;

    // Accumulator update for the arithmetic opcodes; others keep ac.
    function automatic logic [WORD_BITS-1:0] alu(
        input opcode_t              op,
        input logic [WORD_BITS-1:0] ac,
        input logic [WORD_BITS-1:0] operand
    );
        logic [WORD_BITS-1:0] result;
        case (op)
            OP_LOAD: result = operand;
            OP_ADD:  result = ac + operand;
            OP_NEG:  result = (~operand) + WORD_BITS'(1);
            OP_SUB:  result = ac + (~operand) + WORD_BITS'(1);
            default: result = ac;
        endcase
        return result;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/acs_addr_wrap.sv
// Shared address reducer: folds a 13-bit address into the memory depth.
// Depends on acs_pkg. One register stage between the two multiplications.
`default_nettype none

module acs_addr_wrap #(
    parameter int MEM_WORDS = 8192
) (
    input  wire logic                              clk,
    input  wire logic                              load,
    input  wire logic [acs_pkg::ADDR_BITS-1:0]     addr_in,
    output logic      [$clog2(MEM_WORDS)-1:0]      idx
);

    localparam int    IDX_BITS = $clog2(MEM_WORDS);
    localparam int    SHIFT    = 2 * acs_pkg::ADDR_BITS;
    localparam longint RECIP   = ((64'd1 << SHIFT) + MEM_WORDS - 1) / MEM_WORDS;
    localparam int    RW       = $clog2(RECIP + 1);
    localparam int    PW       = acs_pkg::ADDR_BITS + RW;
    localparam int    QW       = PW - SHIFT;

    logic [PW-1:0]                   prod;
    logic [QW-1:0]                   quot_reg;
    logic [acs_pkg::ADDR_BITS-1:0]   addr_reg;
    logic [PW-1:0]                   qm;
    logic [PW-1:0]                   rem;

    // Quotient by reciprocal; exact for every 13-bit address.
    assign prod = PW'(addr_in) * PW'(RECIP);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            addr_reg <= addr_in;
            quot_reg <= prod[PW-1:SHIFT];
        end
    end

    assign qm  = PW'(quot_reg) * PW'(MEM_WORDS);
    assign rem = PW'(addr_reg) - qm;
    assign idx = rem[IDX_BITS-1:0];

endmodule

`default_nettype wire

>>> rtl/core/acs_word_mem.sv
// Word memory with one port: write or registered read at one index a cycle.
// Depends on acs_pkg for the request struct.
`default_nettype none

module acs_word_mem #(
    parameter int MEM_WORDS = 8192
) (
    input  wire logic                              clk,
    input  wire logic [$clog2(MEM_WORDS)-1:0]      idx,
    input  wire acs_pkg::mem_req_t                 req,
    output logic      [acs_pkg::WORD_BITS-1:0]     rd_data
);

    logic [acs_pkg::WORD_BITS-1:0] mem [MEM_WORDS];
    logic [acs_pkg::WORD_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[idx] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> rtl/core/accumulator_cpu_step_top.sv
// Accumulator step block: 16-bit accumulator machine over a word memory.
// Set ip goes to done; write passes the address state; read the address and read-data
// states; execute the address, fetch, operand-address and, for load, add, negate and
// subtract, operand-data states. One word in flight, the next taken as its result appears.
// A second result waits in the last state while the output register is full.
// rst_n (async, low) clears ac, ip, ir and control; memory is undefined until written.
`default_nettype none

module accumulator_cpu_step_top #(
    parameter int MEM_WORDS = 8192
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // action[1:0], address[14:2], data[30:15], pad[31]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [63:0] m_tdata    // acc_value, pointer_value, instruction_value,
                                        // read_word, 16 bits each from the lowest bit up
);

    localparam int IDX_BITS = $clog2(MEM_WORDS);
    localparam int WB       = acs_pkg::WORD_BITS;
    localparam int AB       = acs_pkg::ADDR_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,    // wait for a word; start address reduction
        ST_ADDR,    // index ready: write, or issue read / fetch
        ST_RDATA,   // read word arrives
        ST_FETCH,   // instruction arrives; reduce operand address
        ST_OPADDR,  // operand index ready: store, jump or operand read
        ST_OPDATA,  // operand arrives; update accumulator
        ST_DONE     // hand result to output register
    } state_t;

    state_t               state_reg;
    acs_pkg::action_t     act_reg;
    logic [WB-1:0]        data_reg;
    logic [WB-1:0]        ac_reg;
    logic [WB-1:0]        ip_reg;
    logic [WB-1:0]        ir_reg;
    logic [WB-1:0]        rdw_reg;
    logic                 m_tvalid_reg;
    logic [63:0]          m_tdata_reg;

    acs_pkg::action_t     in_action;
    logic [AB-1:0]        in_address;
    logic [WB-1:0]        in_data;
    logic                 in_accept;
    acs_pkg::opcode_t     opcode;

    logic                 wrap_load;
    logic [AB-1:0]        wrap_addr;
    logic [IDX_BITS-1:0]  mem_idx;
    acs_pkg::mem_req_t    mem_req;
    logic [WB-1:0]        mem_rd_data;

    // Unpack the input word.
    assign in_action  = acs_pkg::action_t'(s_tdata[1:0]);
    assign in_address = s_tdata[14:2];
    assign in_data    = s_tdata[30:15];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign opcode    = acs_pkg::opcode_t'(ir_reg[WB-1:AB]);

    // Feed the shared reducer: item address, fetch pointer or operand address.
    always_comb
    begin
        wrap_load = 1'b0;
        wrap_addr = in_address;
        case (state_reg)
            ST_IDLE:
            begin
                wrap_load = in_accept;
                wrap_addr = (in_action == acs_pkg::ACT_EXEC) ? ip_reg[AB-1:0] : in_address;
            end
            ST_FETCH:
            begin
                wrap_load = 1'b1;
                wrap_addr = mem_rd_data[AB-1:0];
            end
            default:
            begin
                wrap_load = 1'b0;
                wrap_addr = in_address;
            end
        endcase
    end

    // Memory requests follow the state directly.
    always_comb
    begin
        mem_req.wr_en   = 1'b0;
        mem_req.rd_en   = 1'b0;
        mem_req.wr_data = data_reg;
        case (state_reg)
            ST_ADDR:
            begin
                mem_req.wr_en = (act_reg == acs_pkg::ACT_WRITE);
                mem_req.rd_en = (act_reg != acs_pkg::ACT_WRITE);
            end
            ST_OPADDR:
            begin
                mem_req.wr_en   = (opcode == acs_pkg::OP_STORE);
                mem_req.wr_data = ac_reg;
                mem_req.rd_en   = (opcode == acs_pkg::OP_LOAD) || (opcode == acs_pkg::OP_ADD) ||
                                  (opcode == acs_pkg::OP_NEG)  || (opcode == acs_pkg::OP_SUB);
            end
            default:
            begin
                mem_req.wr_en = 1'b0;
                mem_req.rd_en = 1'b0;
            end
        endcase
    end

    acs_addr_wrap #(
        .MEM_WORDS (MEM_WORDS)
    ) u_wrap (
        .clk     (clk),
        .load    (wrap_load),
        .addr_in (wrap_addr),
        .idx     (mem_idx)
    );

    acs_word_mem #(
        .MEM_WORDS (MEM_WORDS)
    ) u_mem (
        .clk     (clk),
        .idx     (mem_idx),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    // Sequencer, architectural registers and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            act_reg      <= acs_pkg::ACT_WRITE;
            data_reg     <= '0;
            ac_reg       <= '0;
            ip_reg       <= '0;
            ir_reg       <= '0;
            rdw_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            // Drop the result once taken, unless the done state loads a new one.
            if (m_tvalid_reg && m_tready && (state_reg != ST_DONE))
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        act_reg  <= in_action;
                        data_reg <= in_data;
                        rdw_reg  <= '0;
                        if (in_action == acs_pkg::ACT_SET_IP)
                        begin
                            ip_reg    <= in_data;
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            state_reg <= ST_ADDR;
                        end
                    end
                end
                ST_ADDR:
                begin
                    case (act_reg)
                        acs_pkg::ACT_WRITE: state_reg <= ST_DONE;
                        acs_pkg::ACT_READ:  state_reg <= ST_RDATA;
                        default:            state_reg <= ST_FETCH;
                    endcase
                end
                ST_RDATA:
                begin
                    rdw_reg   <= mem_rd_data;
                    state_reg <= ST_DONE;
                end
                ST_FETCH:
                begin
                    ir_reg    <= mem_rd_data;
                    ip_reg    <= ip_reg + WB'(1);
                    state_reg <= ST_OPADDR;
                end
                ST_OPADDR:
                begin
                    case (opcode)
                        acs_pkg::OP_LOAD, acs_pkg::OP_ADD, acs_pkg::OP_NEG, acs_pkg::OP_SUB:
                        begin
                            state_reg <= ST_OPDATA;
                        end
                        acs_pkg::OP_JNEG:
                        begin
                            if (ac_reg[WB-1])
                            begin
                                ip_reg <= ir_reg;
                            end
                            state_reg <= ST_DONE;
                        end
                        acs_pkg::OP_JUMP:
                        begin
                            ip_reg    <= ir_reg;
                            state_reg <= ST_DONE;
                        end
                        default:
                        begin
                            state_reg <= ST_DONE;
                        end
                    endcase
                end
                ST_OPDATA:
                begin
                    ac_reg    <= acs_pkg::alu(opcode, ac_reg, mem_rd_data);
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    // Hold until the output register is free or being emptied.
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tdata_reg  <= {rdw_reg, ir_reg, ip_reg, ac_reg};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

>>> rtl/core/acs_port_checker.sv
// Port-level checks for the accumulator step block, bound to its top level.
// Depends on the assertion macro header.
`default_nettype none

`include "accumulator_cpu_step_top_assert.svh"

module acs_port_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [31:0] s_tdata,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata
);

    logic in_accept;

    assign in_accept = s_tvalid && s_tready;

    // A stalled result holds its word.
    `ACS_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // One word at a time: busy right after taking one.
    `ACS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_accept, !s_tready)

    // A new result only appears after the sequencer was busy.
    `ACS_ASSERT_NOW(a_result_from_work, clk, rst_n, $rose(m_tvalid), $past(!s_tready))

    // An input word is never taken while the machine already reports idle-less work.
    `ACS_ASSERT_NEXT(a_no_double_accept, clk, rst_n, in_accept, !(s_tvalid && s_tready))

endmodule

bind accumulator_cpu_step_top acs_port_checker u_port_checker (.*);

`default_nettype wire
